// File: hdl/kwm_pkg.sv
// kwm_pkg: field widths and input function codes for the k-way merge block.
// No dependencies; used by kwm_min_tree and k_way_merge_unit.
package kwm_pkg;

  localparam int KeyW  = 64;
  localparam int TagW  = 32;
  localparam int LaneW = 3;
  localparam int CfgW  = 4;

  typedef enum logic {
    FUNC_RECORD   = 1'b0,
    FUNC_LANE_END = 1'b1
  } func_e;

endpackage

// File: hdl/k_way_merge_unit.sv
// k_way_merge_unit: k-way merge of key-sorted lanes into one ascending stream.
// Path: input register, then lane update, min tree and result register.
// Throughput: one input transaction per cycle, set by the lane update plus min tree,
// unless a result waits on out_ready_i and the next input would emit another.
// Reset clears input/result valid, head valid and lane done marks, the merge-over
// flag, and sets lanes_in_use to 8. Depends on kwm_pkg and kwm_min_tree.
module k_way_merge_unit #(
  parameter int LANES = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [kwm_pkg::CfgW-1:0]   cfg_lanes_in_use_i,

  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       func_i,
  input  logic [kwm_pkg::LaneW-1:0]  lane_i,
  input  logic [kwm_pkg::KeyW-1:0]   key_i,
  input  logic [kwm_pkg::TagW-1:0]   tag_i,

  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [kwm_pkg::KeyW-1:0]   out_key_o,
  output logic [kwm_pkg::LaneW-1:0]  out_lane_o,
  output logic [kwm_pkg::TagW-1:0]   out_tag_o,
  output logic                       finished_o
);

  localparam int IdxW = $clog2(LANES);
  localparam int CntW = $clog2(LANES + 1);
  localparam int CmpW = (CntW > kwm_pkg::CfgW) ? CntW : kwm_pkg::CfgW;
  localparam int LmW  = (CmpW > kwm_pkg::LaneW) ? CmpW : kwm_pkg::LaneW;

  // configuration
  logic [kwm_pkg::CfgW-1:0] lanes_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q <= kwm_pkg::CfgW'(8);
    end else if (cfg_valid_i) begin
      lanes_q <= cfg_lanes_in_use_i;
    end
  end

  // input register
  logic                      s1_valid_q;
  kwm_pkg::func_e            s1_func_q;
  logic [kwm_pkg::LaneW-1:0] s1_lane_q;
  logic [kwm_pkg::KeyW-1:0]  s1_key_q;
  logic [kwm_pkg::TagW-1:0]  s1_tag_q;
  logic                      s1_adv;
  logic                      in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q <= kwm_pkg::func_e'(func_i);
      s1_lane_q <= lane_i;
      s1_key_q  <= key_i;
      s1_tag_q  <= tag_i;
    end
  end

  // lane state
  logic [kwm_pkg::KeyW-1:0] head_key_q [LANES];
  logic [kwm_pkg::TagW-1:0] head_tag_q [LANES];
  logic [LANES-1:0]         head_valid_q, head_valid_d;
  logic [LANES-1:0]         lane_done_q, lane_done_d;
  logic                     merge_over_q, merge_over_d;

  // active count, clamped to 1..LANES
  logic [CmpW-1:0] cfg_ext;
  logic [CmpW-1:0] n_act;

  assign cfg_ext = CmpW'(lanes_q);
  always_comb begin
    if (cfg_ext == '0) begin
      n_act = CmpW'(1);
    end else if (cfg_ext > CmpW'(LANES)) begin
      n_act = CmpW'(LANES);
    end else begin
      n_act = cfg_ext;
    end
  end

  logic                     live;
  logic [LANES-1:0]         act;
  logic [LANES-1:0]         wr_hit;
  logic [LANES-1:0]         eff_valid;
  logic [LANES-1:0]         eff_done;
  logic [kwm_pkg::KeyW-1:0] eff_key [LANES];
  logic [kwm_pkg::TagW-1:0] eff_tag [LANES];

  assign live = s1_valid_q && !merge_over_q;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign act[i]    = CmpW'(i) < n_act;
    assign wr_hit[i] = live && act[i] && (LmW'(s1_lane_q) == LmW'(i))
                       && !head_valid_q[i] && !lane_done_q[i];
    assign eff_valid[i] = head_valid_q[i] | (wr_hit[i] && s1_func_q == kwm_pkg::FUNC_RECORD);
    assign eff_done[i]  = lane_done_q[i] | (wr_hit[i] && s1_func_q == kwm_pkg::FUNC_LANE_END);
    assign eff_key[i]   = wr_hit[i] ? s1_key_q : head_key_q[i];
    assign eff_tag[i]   = wr_hit[i] ? s1_tag_q : head_tag_q[i];
  end

  // minimum over the active heads
  logic                     sel_any;
  logic [IdxW-1:0]          sel_idx;
  logic [kwm_pkg::KeyW-1:0] sel_key;

  kwm_min_tree #(
    .N (LANES)
  ) u_min_tree (
    .valid_i   (eff_valid & act),
    .key_i     (eff_key),
    .any_o     (sel_any),
    .min_idx_o (sel_idx),
    .min_key_o (sel_key)
  );

  logic all_ready;
  logic emit;
  logic [IdxW+kwm_pkg::LaneW-1:0] sel_idx_ext;

  assign all_ready   = &(eff_valid | eff_done | ~act);
  assign emit        = live && all_ready;
  assign sel_idx_ext = {{kwm_pkg::LaneW{1'b0}}, sel_idx};

  // result register
  logic                      out_valid_q;
  logic [kwm_pkg::KeyW-1:0]  out_key_q;
  logic [kwm_pkg::LaneW-1:0] out_lane_q;
  logic [kwm_pkg::TagW-1:0]  out_tag_q;
  logic                      finished_q;

  assign s1_adv     = s1_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_comb begin
    head_valid_d = head_valid_q;
    lane_done_d  = lane_done_q;
    merge_over_d = merge_over_q;
    if (s1_adv) begin
      head_valid_d = eff_valid;
      lane_done_d  = eff_done;
      if (emit && sel_any) begin
        head_valid_d[sel_idx] = 1'b0;
      end
      if (emit && !sel_any) begin
        merge_over_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= '0;
      lane_done_q  <= '0;
      merge_over_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      lane_done_q  <= lane_done_d;
      merge_over_q <= merge_over_d;
      out_valid_q  <= (out_valid_q && !out_ready_i) || (s1_adv && emit);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LANES; i++) begin
      if (s1_adv && wr_hit[i] && s1_func_q == kwm_pkg::FUNC_RECORD) begin
        head_key_q[i] <= s1_key_q;
        head_tag_q[i] <= s1_tag_q;
      end
    end
    if (s1_adv && emit) begin
      // end-of-merge transaction carries zero payload
      out_key_q  <= sel_any ? sel_key : '0;
      out_lane_q <= sel_any ? sel_idx_ext[kwm_pkg::LaneW-1:0] : '0;
      out_tag_q  <= sel_any ? eff_tag[sel_idx] : '0;
      finished_q <= !sel_any;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_key_o   = out_key_q;
  assign out_lane_o  = out_lane_q;
  assign out_tag_o   = out_tag_q;
  assign finished_o  = finished_q;

  a_finish_sets_over : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && emit && !sel_any) |=> merge_over_q)
    else $error("merge-over flag not set after finished transaction");

  a_no_emit_after_over : assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_over_q |-> !emit)
    else $error("result produced after end of merge");

  a_valid_done_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid_q & lane_done_q) == '0)
    else $error("lane holds a head and is marked done");

  a_finished_implies_over : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && finished_q) |-> merge_over_q)
    else $error("finished transaction pending while merge not over");

endmodule

// File: hdl/kwm_min_tree.sv
// kwm_min_tree: combinational minimum tree over the lane heads, ties to lower lane.
// Depends on kwm_pkg for the key width.
module kwm_min_tree #(
  parameter int N = 8
) (
  input  logic [N-1:0]               valid_i,
  input  logic [kwm_pkg::KeyW-1:0]   key_i [N],
  output logic                       any_o,
  output logic [$clog2(N)-1:0]       min_idx_o,
  output logic [kwm_pkg::KeyW-1:0]   min_key_o
);

  localparam int IdxW   = $clog2(N);
  localparam int Leaves = 1 << IdxW;

  // heap layout: node j combines 2j (lower lanes) and 2j+1
  logic                     node_v [1:2*Leaves-1];
  logic [kwm_pkg::KeyW-1:0] node_k [1:2*Leaves-1];
  logic [IdxW-1:0]          node_i [1:2*Leaves-1];

  for (genvar g = 0; g < Leaves; g++) begin : g_leaf
    if (g < N) begin : g_used
      assign node_v[Leaves+g] = valid_i[g];
      assign node_k[Leaves+g] = key_i[g];
      assign node_i[Leaves+g] = IdxW'(g);
    end else begin : g_pad
      assign node_v[Leaves+g] = 1'b0;
      assign node_k[Leaves+g] = '0;
      assign node_i[Leaves+g] = '0;
    end
  end

  for (genvar j = 1; j < Leaves; j++) begin : g_node
    logic take_r;
    // right side wins only on a strictly smaller key
    assign take_r = node_v[2*j+1] && (!node_v[2*j] || (node_k[2*j+1] < node_k[2*j]));
    assign node_v[j] = node_v[2*j] | node_v[2*j+1];
    assign node_k[j] = take_r ? node_k[2*j+1] : node_k[2*j];
    assign node_i[j] = take_r ? node_i[2*j+1] : node_i[2*j];
  end

  assign any_o     = node_v[1];
  assign min_idx_o = node_i[1];
  assign min_key_o = node_k[1];

endmodule

// File: sim/testbench.sv
// Self-checking testbench for k_way_merge_unit: directed and random lane traffic
// on valid/ready channels, checked against an in-bench merge predictor.
// Depends on kwm_pkg and the k_way_merge_unit RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LANES          = 8;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct {
    logic [kwm_pkg::KeyW-1:0]  key;
    logic [kwm_pkg::LaneW-1:0] lane;
    logic [kwm_pkg::TagW-1:0]  tag;
    logic                      finished;
  } merge_out_t;

  logic                       clk_i              = 1'b0;
  logic                       rst_ni             = 1'b0;
  logic                       cfg_valid_i        = 1'b0;
  logic                       cfg_ready_o;
  logic [kwm_pkg::CfgW-1:0]   cfg_lanes_in_use_i = '0;
  logic                       in_valid_i         = 1'b0;
  logic                       in_ready_o;
  logic                       func_i             = 1'b0;
  logic [kwm_pkg::LaneW-1:0]  lane_i             = '0;
  logic [kwm_pkg::KeyW-1:0]   key_i              = '0;
  logic [kwm_pkg::TagW-1:0]   tag_i              = '0;
  logic                       out_valid_o;
  logic                       out_ready_i        = 1'b0;
  logic [kwm_pkg::KeyW-1:0]   out_key_o;
  logic [kwm_pkg::LaneW-1:0]  out_lane_o;
  logic [kwm_pkg::TagW-1:0]   out_tag_o;
  logic                       finished_o;

  // predictor state
  logic [kwm_pkg::KeyW-1:0]  head_key   [LANES];
  logic [kwm_pkg::TagW-1:0]  head_tag   [LANES];
  bit                        head_valid [LANES];
  bit                        lane_done  [LANES];
  bit                        merge_over;
  logic [kwm_pkg::CfgW-1:0]  lanes_cfg = 4'd8;
  merge_out_t                pending_merge_out [$];

  bit calm = 1'b0;
  int errors, records_checked, markers_checked;
  int items_sent, items_applied, cfg_writes;
  int quiet_cycles, stall_left;

  k_way_merge_unit #(.LANES(LANES)) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_lanes_in_use_i (cfg_lanes_in_use_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .func_i             (func_i),
    .lane_i             (lane_i),
    .key_i              (key_i),
    .tag_i              (tag_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_key_o          (out_key_o),
    .out_lane_o         (out_lane_o),
    .out_tag_o          (out_tag_o),
    .finished_o         (finished_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // out-of-range counts clamp to 1..LANES
  function automatic int active_count();
    int n;
    n = int'(lanes_cfg);
    if (n < 1) n = 1;
    if (n > LANES) n = LANES;
    return n;
  endfunction

  function automatic bit lane_open(int l);
    return l < active_count() && !head_valid[l] && !lane_done[l];
  endfunction

  function automatic int free_lane();
    int start, l;
    start = $urandom_range(0, LANES - 1);
    for (int i = 0; i < LANES; i++) begin
      l = (start + i) % LANES;
      if (lane_open(l)) return l;
    end
    return -1;
  endfunction

  // small keys give plenty of ties; the rest spread over the full range
  function automatic logic [kwm_pkg::KeyW-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return {$urandom, $urandom};
    if (r < 8) return kwm_pkg::KeyW'($urandom_range(0, 15));
    if (r == 8) return '1 - kwm_pkg::KeyW'($urandom_range(0, 3));
    return {($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0, $urandom};
  endfunction

  // apply one accepted input to the predicted lane state, queue any result
  task automatic merge_step(input kwm_pkg::func_e f, input logic [kwm_pkg::LaneW-1:0] ln,
                            input logic [kwm_pkg::KeyW-1:0] k,
                            input logic [kwm_pkg::TagW-1:0] t,
                            output bit applied);
    int n, best;
    bit all_set, found;
    merge_out_t r;
    applied = 1'b0;
    if (merge_over) return;
    n = active_count();
    if (lane_open(int'(ln))) begin
      applied = 1'b1;
      if (f == kwm_pkg::FUNC_RECORD) begin
        head_key[ln]   = k;
        head_tag[ln]   = t;
        head_valid[ln] = 1'b1;
      end else begin
        lane_done[ln] = 1'b1;
      end
    end
    all_set = 1'b1;
    for (int i = 0; i < n; i++)
      if (!head_valid[i] && !lane_done[i]) all_set = 1'b0;
    if (!all_set) return;
    found = 1'b0;
    best  = 0;
    for (int i = 0; i < n; i++) begin
      if (head_valid[i] && (!found || head_key[i] < head_key[best])) begin
        best  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      r = '{head_key[best], kwm_pkg::LaneW'(best), head_tag[best], 1'b0};
      head_valid[best] = 1'b0;
    end else begin
      r = '{'0, '0, '0, 1'b1};
      merge_over = 1'b1;
    end
    pending_merge_out.push_back(r);
  endtask

  task automatic send_item(input kwm_pkg::func_e f, input logic [kwm_pkg::LaneW-1:0] ln,
                           input logic [kwm_pkg::KeyW-1:0] k,
                           input logic [kwm_pkg::TagW-1:0] t);
    bit applied;
    int gap;
    in_valid_i <= 1'b1;
    func_i     <= f;
    lane_i     <= ln;
    key_i      <= k;
    tag_i      <= t;
    do @(posedge clk_i); while (!in_ready_o);
    merge_step(f, ln, k, t, applied);
    items_sent++;
    if (applied) items_applied++;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off the sender until all results are out and the pipeline is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_merge_out.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_lanes(input logic [kwm_pkg::CfgW-1:0] v);
    cfg_valid_i        <= 1'b1;
    cfg_lanes_in_use_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    lanes_cfg = v;
    cfg_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [kwm_pkg::KeyW-1:0] got,
                                 input logic [kwm_pkg::KeyW-1:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    merge_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_merge_out.size() == 0) begin
        report_mismatch("result with none expected, key", out_key_o, '0);
      end else begin
        e = pending_merge_out.pop_front();
        if (out_key_o !== e.key) report_mismatch("out_key", out_key_o, e.key);
        if (out_lane_o !== e.lane)
          report_mismatch("out_lane", kwm_pkg::KeyW'(out_lane_o), kwm_pkg::KeyW'(e.lane));
        if (out_tag_o !== e.tag)
          report_mismatch("out_tag", kwm_pkg::KeyW'(out_tag_o), kwm_pkg::KeyW'(e.tag));
        if (finished_o !== e.finished)
          report_mismatch("finished", kwm_pkg::KeyW'(finished_o),
                          kwm_pkg::KeyW'(e.finished));
        if (e.finished) markers_checked++;
        else records_checked++;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (calm || $urandom_range(0, 3) != 0) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= 1'b0;
      stall_left  <= idle_len();
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // reset lane count, key/tag extremes, ties to the lowest lane, occupied lane
  task automatic test_heads_at_reset();
    logic [kwm_pkg::KeyW-1:0] keys [LANES];
    keys = '{'1, '0, 64'h8000_0000_0000_0000, '0, 64'd7, 64'd7,
             64'hFFFF_FFFF_FFFF_FFFE, 64'h7FFF_FFFF_FFFF_FFFF};
    calm = 1'b0;
    for (int l = 0; l < LANES; l++)
      send_item(kwm_pkg::FUNC_RECORD, kwm_pkg::LaneW'(l), keys[l],
                (l == 0) ? '1 : (l == 1) ? '0 : $urandom);
    send_item(kwm_pkg::FUNC_RECORD, 3'd2, '0, 32'hDEAD_BEEF);
    send_item(kwm_pkg::FUNC_RECORD, 3'd1, '0, 32'hA5A5_5A5A);
    send_item(kwm_pkg::FUNC_RECORD, 3'd1, '1, 32'h5A5A_A5A5);
    send_item(kwm_pkg::FUNC_RECORD, 3'd3, 64'd7, $urandom);
  endtask

  // count of one, zero and fifteen; items for inactive lanes still trigger selection
  task automatic test_count_extremes();
    settle();
    write_lanes(4'd1);
    send_item(kwm_pkg::FUNC_RECORD, 3'd5, 64'd1, $urandom);
    send_item(kwm_pkg::FUNC_RECORD, 3'd0, 64'd3, $urandom);
    settle();
    write_lanes(4'd0);
    send_item(kwm_pkg::FUNC_LANE_END, 3'd7, '0, '0);
    send_item(kwm_pkg::FUNC_RECORD, 3'd0, '0, '1);
    settle();
    write_lanes(4'd15);
    send_item(kwm_pkg::FUNC_RECORD, 3'd0, 64'd2, $urandom);
  endtask

  // mostly refills of the drained lane, with noise on busy and inactive lanes
  task automatic test_random_merge();
    logic [kwm_pkg::CfgW-1:0] counts [12];
    int target, ln, nl;
    kwm_pkg::func_e f;
    counts = '{4'd8, 4'd3, 4'd1, 4'd5, 4'd2, 4'd8, 4'd0, 4'd7, 4'd15, 4'd4, 4'd6, 4'd8};
    foreach (counts[p]) begin
      settle();
      write_lanes(counts[p]);
      calm   = (p == 0);
      target = items_applied + 85;
      while (items_applied < target) begin
        ln = free_lane();
        if (ln >= 0 && $urandom_range(0, 99) < 85) begin
          send_item(kwm_pkg::FUNC_RECORD, kwm_pkg::LaneW'(ln), pick_key(), $urandom);
        end else begin
          nl = $urandom_range(0, LANES - 1);
          f  = kwm_pkg::func_e'($urandom_range(0, 1));
          // keep lanes alive until the closing test
          if (f == kwm_pkg::FUNC_LANE_END && lane_open(nl)) f = kwm_pkg::FUNC_RECORD;
          send_item(f, kwm_pkg::LaneW'(nl), pick_key(), $urandom);
        end
      end
    end
    calm = 1'b0;
  endtask

  // lanes run out one by one, then the merge is over and everything is ignored
  task automatic test_lane_end();
    int ln;
    kwm_pkg::func_e f;
    settle();
    write_lanes(4'd8);
    while (!merge_over) begin
      ln = free_lane();
      if (ln < 0 || $urandom_range(0, 9) == 0) begin
        send_item(kwm_pkg::func_e'($urandom_range(0, 1)),
                  kwm_pkg::LaneW'($urandom_range(0, LANES - 1)), pick_key(), $urandom);
      end else begin
        f = ($urandom_range(0, 4) == 0) ? kwm_pkg::FUNC_LANE_END : kwm_pkg::FUNC_RECORD;
        send_item(f, kwm_pkg::LaneW'(ln), pick_key(), $urandom);
      end
    end
    for (int i = 0; i < 6; i++)
      send_item(kwm_pkg::func_e'(i % 2), kwm_pkg::LaneW'(i), pick_key(), $urandom);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_heads_at_reset();
    test_count_extremes();
    test_random_merge();
    test_lane_end();
    settle();
    repeat (4) @(posedge clk_i);
    $display("Sent %0d input transactions (%0d changed lane state) over %0d lane-count writes",
             items_sent, items_applied, cfg_writes);
    $display("Checked %0d merged records and %0d end-of-merge markers",
             records_checked, markers_checked);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
